@@ sv/ctv_pkg.sv @@
// ----------------------------------------------------------------------------
// ctv_pkg: shared types and constants of the camera tag visibility test
// Field widths, configuration register indexes, reset values and the
// whole-degree sine table used by the facing test.
// ----------------------------------------------------------------------------
package ctv_pkg;

  localparam int COORD_W   = 16;
  localparam int YAW_W     = 9;
  localparam int RANGE_W   = 15;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [YAW_W-1:0]          yaw_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_HEIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENS_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_TOP     = 4'd3;

  localparam logic [RANGE_W-1:0] RANGE_LIM_RST   = 15'd3200;
  localparam logic [RANGE_W-1:0] CAM_HEIGHT_RST  = 15'd384;
  localparam coord_t             LENS_HEIGHT_RST = 16'sd384;
  localparam coord_t             TAN_TOP_RST     = 16'sd4096;

  // Three inches in 1/16 inch units.
  localparam logic signed [17:0] MARK_TOP_OFFSET = 18'sd48;
  localparam int                 TAN_FRAC_BITS   = 12;

  localparam yaw_t FULL_TURN   = 9'd360;
  localparam yaw_t HALF_TURN   = 9'd180;
  localparam yaw_t QUARTER     = 9'd90;
  localparam yaw_t THREE_QUART = 9'd270;

  typedef struct packed {
    logic [RANGE_W-1:0] range_lim;
    logic [RANGE_W-1:0] cam_height;
    coord_t             lens_height;
    coord_t             tan_top;
  } cfg_t;

  // round(16384 * sin(k degrees)) for k = 0..90.
  localparam logic [14:0] QSINE [91] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // Q1.14 sine of an angle already reduced to 0..359 degrees.
  function automatic logic signed [15:0] deg_sine(input yaw_t a);
    yaw_t        idx;
    logic        neg;
    logic [15:0] mag;
    if (a <= QUARTER) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= HALF_TURN) begin
      idx = HALF_TURN - a;
      neg = 1'b0;
    end else if (a <= THREE_QUART) begin
      idx = a - HALF_TURN;
      neg = 1'b1;
    end else begin
      idx = FULL_TURN - a;
      neg = 1'b1;
    end
    mag = {1'b0, QSINE[idx[6:0]]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

@@ sv/ctv_in_if.sv @@
// ----------------------------------------------------------------------------
// ctv_in_if: request channel of the visibility test
// Carries one camera position and marker pose per request.
// ----------------------------------------------------------------------------
interface ctv_in_if import ctv_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t cam_x;
  coord_t cam_y;
  coord_t mark_x;
  coord_t mark_y;
  coord_t mark_z;
  yaw_t   mark_yaw;

  modport source (output valid, cam_x, cam_y, mark_x, mark_y, mark_z, mark_yaw,
                  input ready);
  modport sink (input valid, cam_x, cam_y, mark_x, mark_y, mark_z, mark_yaw,
                output ready);
endinterface

@@ sv/ctv_out_if.sv @@
// ----------------------------------------------------------------------------
// ctv_out_if: result channel of the visibility test
// Carries the coverage flag of one request.
// ----------------------------------------------------------------------------
interface ctv_out_if ();
  logic valid;
  logic ready;
  logic covered;

  modport source (output valid, covered, input ready);
  modport sink (input valid, covered, output ready);
endinterface

@@ sv/ctv_cfg.sv @@
// ----------------------------------------------------------------------------
// ctv_cfg: configuration registers
// Write-only register file for range limit, camera heights and view tangent.
// ----------------------------------------------------------------------------
module ctv_cfg import ctv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_lim   <= RANGE_LIM_RST;
      cfg.cam_height  <= CAM_HEIGHT_RST;
      cfg.lens_height <= LENS_HEIGHT_RST;
      cfg.tan_top     <= TAN_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LIM:   cfg.range_lim   <= cfg_data[RANGE_W-1:0];
        REG_CAM_HEIGHT:  cfg.cam_height  <= cfg_data[RANGE_W-1:0];
        REG_LENS_HEIGHT: cfg.lens_height <= $signed(cfg_data);
        REG_TAN_TOP:     cfg.tan_top     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

@@ sv/camera_tag_visibility_test_core.sv @@
// ----------------------------------------------------------------------------
// camera_tag_visibility_test_core: camera-to-marker visibility pipeline
// Range, view-ray height and facing tests; a request per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle when not stalled; its coverage
// flag passes five register stages; the rate is set by the pipeline, which
// has one stage for offsets and table lookup, one for squares and sine
// products, one for sums and the range compare, one for the wide height and
// facing products and one output register. Each stage holds its item only
// while the stage after it is full, so a stalled result does not block
// requests until the pipeline has filled. Configuration writes take effect
// at once and are meant to be made while no request is in flight.
module camera_tag_visibility_test_core import ctv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ctv_in_if.sink               req,
  ctv_out_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;

  ctv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5 || res.ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;

  // Stage 1: offsets, view-ray rise and sine/cosine of the marker yaw.
  logic signed [16:0] dx1, dy1;
  logic signed [17:0] dz1, r1;
  logic signed [15:0] s1, c1;
  yaw_t               yaw_m, cos_a, cos_m;

  always_comb begin
    yaw_m = (req.mark_yaw >= FULL_TURN) ? req.mark_yaw - FULL_TURN : req.mark_yaw;
    cos_a = yaw_m + QUARTER;
    cos_m = (cos_a >= FULL_TURN) ? cos_a - FULL_TURN : cos_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && req.valid) begin
      dx1 <= 17'(req.cam_x) - 17'(req.mark_x);
      dy1 <= 17'(req.cam_y) - 17'(req.mark_y);
      dz1 <= $signed({3'b000, cfg.cam_height}) - 18'(req.mark_z);
      r1  <= 18'(req.mark_z) + MARK_TOP_OFFSET - 18'(cfg.lens_height);
      s1  <= deg_sine(yaw_m);
      c1  <= deg_sine(cos_m);
    end
  end

  // Stage 2: squares and rotation products.
  logic signed [33:0] dx_sq, dy_sq;
  logic signed [35:0] dz_sq, r_sq;
  logic signed [31:0] tt_sq;
  logic signed [32:0] pxc, pys, pyc, pxs;
  logic [29:0]        mr_sq;

  logic [31:0]        dx2_2, dy2_2, dz2_2;
  logic [32:0]        r2_2;
  logic [30:0]        tt2;
  logic [29:0]        mr2_2;
  logic signed [32:0] pxc2, pys2, pyc2, pxs2;
  logic               rpos2, tneg2;

  always_comb begin
    dx_sq = 34'(dx1) * 34'(dx1);
    dy_sq = 34'(dy1) * 34'(dy1);
    dz_sq = 36'(dz1) * 36'(dz1);
    r_sq  = 36'(r1) * 36'(r1);
    tt_sq = 32'(cfg.tan_top) * 32'(cfg.tan_top);
    pxc   = 33'(dx1) * 33'(c1);
    pys   = 33'(dy1) * 33'(s1);
    pyc   = 33'(dy1) * 33'(c1);
    pxs   = 33'(dx1) * 33'(s1);
    mr_sq = 30'(cfg.range_lim) * 30'(cfg.range_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      dx2_2 <= dx_sq[31:0];
      dy2_2 <= dy_sq[31:0];
      dz2_2 <= dz_sq[31:0];
      r2_2  <= r_sq[32:0];
      tt2   <= tt_sq[30:0];
      mr2_2 <= mr_sq;
      pxc2  <= pxc;
      pys2  <= pys;
      pyc2  <= pyc;
      pxs2  <= pxs;
      rpos2 <= !r1[17] && (r1 != 18'sd0);
      tneg2 <= cfg.tan_top[15];
    end
  end

  // Stage 3: planar and 3D distance sums, range test, rotated offset.
  logic [32:0]        dxy_sum;
  logic [33:0]        d_sum;
  logic signed [32:0] rx_sum, ry_sum;

  logic [32:0]        dxy3;
  logic [32:0]        r2_3;
  logic [30:0]        tt3;
  logic signed [31:0] rx3, ry3;
  logic               range_ok3, rpos3, tneg3;

  always_comb begin
    dxy_sum = {1'b0, dx2_2} + {1'b0, dy2_2};
    d_sum   = {1'b0, dxy_sum} + {2'b00, dz2_2};
    rx_sum  = pxc2 + pys2;
    ry_sum  = pyc2 - pxs2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      dxy3      <= dxy_sum;
      range_ok3 <= d_sum <= {4'b0000, mr2_2};
      rx3       <= rx_sum[31:0];
      ry3       <= ry_sum[31:0];
      r2_3      <= r2_2;
      tt3       <= tt2;
      rpos3     <= rpos2;
      tneg3     <= tneg2;
    end
  end

  // Stage 4: planar distance times tangent squared, split in two halves,
  // and the squared rotated offsets.
  logic [31:0] rx_mag, ry_mag;
  logic [47:0] ph_prod;
  logic [46:0] pl_prod;
  logic [61:0] rx_prod, ry_prod;

  logic [47:0] ph4;
  logic [46:0] pl4;
  logic [61:0] rx2_4, ry2_4;
  logic [32:0] r2_4;
  logic        range_ok4, rx_neg4, rpos4, tneg4;

  always_comb begin
    rx_mag  = rx3[31] ? 32'(-rx3) : 32'(rx3);
    ry_mag  = ry3[31] ? 32'(-ry3) : 32'(ry3);
    ph_prod = 48'(dxy3[32:16]) * 48'(tt3);
    pl_prod = 47'(dxy3[15:0]) * 47'(tt3);
    rx_prod = 62'(rx_mag[30:0]) * 62'(rx_mag[30:0]);
    ry_prod = 62'(ry_mag[30:0]) * 62'(ry_mag[30:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      ph4       <= ph_prod;
      pl4       <= pl_prod;
      rx2_4     <= rx_prod;
      ry2_4     <= ry_prod;
      r2_4      <= r2_3;
      range_ok4 <= range_ok3;
      rx_neg4   <= rx3[31];
      rpos4     <= rpos3;
      tneg4     <= tneg3;
    end
  end

  // Stage 5: exact height compare through squares, facing compare, result.
  logic [63:0] ht_prod, rise_sq, ry3x, rx_cmp;
  logic        height_fail, facing_fail;
  logic        covered;

  always_comb begin
    ht_prod = {ph4, 16'h0000} + {17'h00000, pl4};
    rise_sq = {7'h00, r2_4, 24'h000000};
    if (!tneg4) begin
      height_fail = rpos4 && (ht_prod < rise_sq);
    end else begin
      height_fail = rpos4 || (ht_prod > rise_sq);
    end
    // The offset lies within 30 degrees of the facing when 3*y*y <= x*x.
    ry3x        = {2'b00, ry2_4} + {1'b0, ry2_4, 1'b0};
    rx_cmp      = {2'b00, rx2_4};
    facing_fail = rx_neg4 || (ry3x > rx_cmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      covered <= range_ok4 && !height_fail && !facing_fail;
    end
  end

  assign res.valid   = v5;
  assign res.covered = covered;

  a_range_fail: assert property (@(posedge clk) disable iff (rst)
    (v4 && rdy5 && !range_ok4) |=> !covered)
    else $error("item beyond range reported as covered");

  a_behind_fail: assert property (@(posedge clk) disable iff (rst)
    (v4 && rdy5 && rx_neg4) |=> !covered)
    else $error("camera behind marker reported as covered");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule
